FILE: rtl/bfmd_pkg.sv
// ----------------------------------------------------------------------------
// Box filter downsampler package
// Shared constants, configuration codes and the effective configuration type.
// ----------------------------------------------------------------------------
package bfmd_pkg;

  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 13;
  localparam int LOG2_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_DIVIDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 2'd3;

  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH  = 13'd256;
  localparam logic [LOG2_W-1:0]  RST_LOG2_DIVIDER = 3'd1;

  typedef enum logic [1:0] {
    FMT_RGBA8 = 2'd0,
    FMT_RG16U = 2'd1,
    FMT_RG16S = 2'd2,
    FMT_RG8S  = 2'd3
  } fmt_t;

  localparam logic [1:0] ALPHA_FORCE  = 2'd0;
  localparam logic [1:0] ALPHA_THRESH = 2'd1;
  localparam logic [1:0] ALPHA_PASS   = 2'd2;

  localparam logic [7:0] ALPHA_HALF   = 8'h80;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [LOG2_W-1:0]  log2;
    fmt_t               fmt;
    logic [1:0]         alpha;
  } cfg_t;

endpackage

FILE: rtl/bfmd_if.sv
// ----------------------------------------------------------------------------
// Box filter downsampler channels
// Valid/ready channels for source pixels, results and configuration writes.
// ----------------------------------------------------------------------------
interface bfmd_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfmd_pkg::PIXEL_W-1:0] src_pixel;
  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

interface bfmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bfmd_pkg::PIXEL_W-1:0] dst_pixel;
  logic                         format_error;
  modport source (output valid, output dst_pixel, output format_error, input ready);
  modport sink (input valid, input dst_pixel, input format_error, output ready);
endinterface

interface bfmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfmd_pkg::CFG_IDX_W-1:0]  index;
  logic [bfmd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bfmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Box filter downsampler configuration registers
// Holds the four registers and derives the clamped effective configuration.
// ----------------------------------------------------------------------------
module bfmd_cfg_regs #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_LOG2_DIVIDER = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  bfmd_cfg_if.sink          cfg_if,
  output bfmd_pkg::cfg_t    cfg,
  output logic              restart
);

  localparam logic [14:0] MAXW = 15'(MAX_WIDTH);
  localparam logic [3:0]  MAXL = 4'(MAX_LOG2_DIVIDER);

  logic [bfmd_pkg::WIDTH_W-1:0] image_width_r;
  logic [bfmd_pkg::LOG2_W-1:0]  log2_divider_r;
  bfmd_pkg::fmt_t               pixel_format_r;
  logic [1:0]                   alpha_mode_r;

  logic                         wr;
  logic [bfmd_pkg::LOG2_W-1:0]  l_eff;
  logic [14:0]                  w_lim;
  logic [bfmd_pkg::WIDTH_W-1:0] w_a;
  logic [bfmd_pkg::WIDTH_W-1:0] d_val;
  logic [bfmd_pkg::WIDTH_W-1:0] w_b;

  assign cfg_if.ready = 1'b1;
  assign wr           = cfg_if.valid;
  assign restart      = wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bfmd_pkg::RST_IMAGE_WIDTH;
      log2_divider_r <= bfmd_pkg::RST_LOG2_DIVIDER;
      pixel_format_r <= bfmd_pkg::FMT_RGBA8;
      alpha_mode_r   <= bfmd_pkg::ALPHA_PASS;
    end else if (wr) begin
      case (cfg_if.index)
        bfmd_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_if.data[bfmd_pkg::WIDTH_W-1:0];
        end
        bfmd_pkg::REG_LOG2_DIVIDER: begin
          log2_divider_r <= cfg_if.data[bfmd_pkg::LOG2_W-1:0];
        end
        bfmd_pkg::REG_PIXEL_FORMAT: begin
          pixel_format_r <= bfmd_pkg::fmt_t'(cfg_if.data[1:0]);
        end
        bfmd_pkg::REG_ALPHA_MODE: begin
          alpha_mode_r <= cfg_if.data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    l_eff = log2_divider_r;
    if (l_eff == '0) begin
      l_eff = 3'd1;
    end
    if ({1'b0, l_eff} > MAXL) begin
      l_eff = MAXL[bfmd_pkg::LOG2_W-1:0];
    end
    w_lim = (15'(image_width_r) > MAXW) ? MAXW : 15'(image_width_r);
    w_a   = w_lim[bfmd_pkg::WIDTH_W-1:0];
    d_val = 13'(1) << l_eff;
    w_b   = (w_a < d_val) ? d_val : w_a;
    cfg.width = w_b & ~(d_val - 13'd1);
    cfg.log2  = l_eff;
    cfg.fmt   = pixel_format_r;
    cfg.alpha = alpha_mode_r;
  end

endmodule

FILE: rtl/bfmd_line_mem.sv
// ----------------------------------------------------------------------------
// Box filter downsampler line store
// One write port and one registered read port holding per-column sums.
// ----------------------------------------------------------------------------
module bfmd_line_mem #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 80,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bfmd_pack.sv
// ----------------------------------------------------------------------------
// Box filter downsampler result packing
// Divides the block sums and packs the destination pixel per format.
// ----------------------------------------------------------------------------
module bfmd_pack #(
  parameter int SUM_W = 22
) (
  input  logic [SUM_W-1:0]             r_sum,
  input  logic [SUM_W-1:0]             g_sum,
  input  logic [SUM_W-1:0]             b_sum,
  input  logic [SUM_W-1:0]             a_sum,
  input  bfmd_pkg::cfg_t               cfg,
  output logic [bfmd_pkg::PIXEL_W-1:0] dst_pixel,
  output logic                         format_error
);

  logic [3:0]              sh;
  logic [SUM_W-1:0]        r_sh;
  logic [SUM_W-1:0]        g_sh;
  logic [SUM_W-1:0]        b_sh;
  logic [SUM_W-1:0]        a_sh;
  logic [7:0]              a_out;
  logic signed [SUM_W-1:0] r_bias;
  logic signed [SUM_W-1:0] g_bias;
  logic signed [SUM_W-1:0] r_q;
  logic signed [SUM_W-1:0] g_q;

  always_comb begin
    sh   = {cfg.log2, 1'b0};
    r_sh = r_sum >> sh;
    g_sh = g_sum >> sh;
    b_sh = b_sum >> sh;
    a_sh = a_sum >> sh;

    case (cfg.alpha)
      bfmd_pkg::ALPHA_FORCE:  a_out = bfmd_pkg::ALPHA_OPAQUE;
      bfmd_pkg::ALPHA_THRESH: a_out = (a_sh[7:0] >= bfmd_pkg::ALPHA_HALF) ?
                                      bfmd_pkg::ALPHA_OPAQUE : 8'h00;
      default:                a_out = a_sh[7:0];
    endcase

    r_bias = signed'(r_sum) + (r_sum[SUM_W-1] ? SUM_W'(3) : '0);
    g_bias = signed'(g_sum) + (g_sum[SUM_W-1] ? SUM_W'(3) : '0);
    r_q    = r_bias >>> 2;
    g_q    = g_bias >>> 2;

    format_error = (cfg.fmt != bfmd_pkg::FMT_RGBA8) && (cfg.log2 > 3'd1);

    case (cfg.fmt)
      bfmd_pkg::FMT_RGBA8: dst_pixel = {a_out, b_sh[7:0], g_sh[7:0], r_sh[7:0]};
      bfmd_pkg::FMT_RG16U: dst_pixel = {g_sum[17:2], r_sum[17:2]};
      bfmd_pkg::FMT_RG16S: dst_pixel = {g_q[15:0], r_q[15:0]};
      bfmd_pkg::FMT_RG8S:  dst_pixel = {16'h0000, g_q[7:0], r_q[7:0]};
      default:             dst_pixel = '0;
    endcase

    if (format_error) begin
      dst_pixel = '0;
    end
  end

endmodule

FILE: rtl/box_filter_mipmap_downsampler_unit.sv
// ----------------------------------------------------------------------------
// Box filter mipmap downsampler
// Sums each D by D block of a raster pixel stream and emits the block average.
// ----------------------------------------------------------------------------
// Source pixels enter on in_if in raster order, one item per clock. A line
// store holds one partial sum per destination column and channel; each item
// reads its column entry at acceptance and writes the updated sum back from the
// accumulate stage, with the sum forwarded when the next item hits the same entry.
// The last pixel of a block (bottom-right) produces one item on out_if, held
// in an output register; out_if.valid rises when that pixel leaves the accumulate
// stage and its result is loaded into that register. Other pixels produce no result.
// Throughput is one pixel per cycle, set by the single read and write port
// of the line store. When the receiver stalls, a pending result stays in the
// output register while pixels continue to be taken; in_if.ready drops only
// when a further block result is ready and the output register is still full.
// Configuration writes on cfg_if are accepted every cycle and restart the image at its first
// pixel. They are made while the stream is idle; the user must keep to this, the unit does not enforce it.
// Reset loads the register defaults and the first-pixel position. The line
// store needs no clearing, since every entry is written by the first pixel
// of its block before it is read.
// ----------------------------------------------------------------------------
module box_filter_mipmap_downsampler_unit #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_LOG2_DIVIDER = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  bfmd_cfg_if.sink    cfg_if,
  bfmd_in_if.sink     in_if,
  bfmd_out_if.source  out_if
);

  localparam int MAX_L_EFF  = (MAX_LOG2_DIVIDER > 7) ? 7 : MAX_LOG2_DIVIDER;
  localparam int SUM_W      = (8 + 2 * MAX_L_EFF > 18) ? 8 + 2 * MAX_L_EFF : 18;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int ROW_W      = MAX_L_EFF;
  localparam int COL_W      = bfmd_pkg::WIDTH_W;
  localparam int WORD_W     = 4 * SUM_W;

  bfmd_pkg::cfg_t cfg;
  logic           restart;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic              accept;
  logic              in_ready;
  logic [COL_W-1:0]  cmask;
  logic [COL_W-1:0]  col_inc;
  logic [COL_W-1:0]  dc_full;
  logic [ADDR_W-1:0] dc;
  logic [ROW_W-1:0]  row_max;
  logic              first_in, last_in;
  logic [SUM_W-1:0]  r_in, g_in, b_in, a_in;

  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_dc_r;
  logic              s1_first_r, s1_last_r;
  logic [WORD_W-1:0] s1_px_r;
  logic              s1_fwd_r;
  logic [WORD_W-1:0] s1_fwd_data_r;
  logic              s1_adv;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] sum;

  logic [bfmd_pkg::PIXEL_W-1:0] dst_pixel;
  logic                         format_error;
  logic                         out_valid_r, out_valid_nxt;
  logic [bfmd_pkg::PIXEL_W-1:0] out_dst_r;
  logic                         out_err_r;
  logic                         out_load;

  bfmd_cfg_regs #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_LOG2_DIVIDER (MAX_LOG2_DIVIDER)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .cfg     (cfg),
    .restart (restart)
  );

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_if.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  always_comb begin
    cmask    = COL_W'((14'd1 << cfg.log2) - 14'd1);
    row_max  = ROW_W'((8'd1 << cfg.log2) - 8'd1);
    dc_full  = col_r >> cfg.log2;
    dc       = dc_full[ADDR_W-1:0];
    first_in = (row_r == '0) && ((col_r & cmask) == '0);
    last_in  = (row_r == row_max) && ((col_r & cmask) == cmask);
    col_inc  = col_r + COL_W'(1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_inc >= cfg.width) begin
        col_nxt = '0;
        row_nxt = (row_r == row_max) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_comb begin
    case (cfg.fmt)
      bfmd_pkg::FMT_RGBA8: begin
        r_in = SUM_W'(in_if.src_pixel[7:0]);
        g_in = SUM_W'(in_if.src_pixel[15:8]);
        b_in = SUM_W'(in_if.src_pixel[23:16]);
        a_in = SUM_W'(in_if.src_pixel[31:24]);
      end
      bfmd_pkg::FMT_RG16U: begin
        r_in = SUM_W'(in_if.src_pixel[15:0]);
        g_in = SUM_W'(in_if.src_pixel[31:16]);
        b_in = '0;
        a_in = '0;
      end
      bfmd_pkg::FMT_RG16S: begin
        r_in = {{(SUM_W-16){in_if.src_pixel[15]}}, in_if.src_pixel[15:0]};
        g_in = {{(SUM_W-16){in_if.src_pixel[31]}}, in_if.src_pixel[31:16]};
        b_in = '0;
        a_in = '0;
      end
      default: begin
        r_in = {{(SUM_W-8){in_if.src_pixel[7]}}, in_if.src_pixel[7:0]};
        g_in = {{(SUM_W-8){in_if.src_pixel[15]}}, in_if.src_pixel[15:8]};
        b_in = '0;
        a_in = '0;
      end
    endcase
  end

  bfmd_line_mem #(
    .DEPTH  (LINE_DEPTH),
    .DATA_W (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (dc),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_dc_r),
    .wr_data (sum)
  );

  always_comb begin
    base = s1_fwd_r ? s1_fwd_data_r : rd_data;
    if (s1_first_r) begin
      sum = s1_px_r;
    end else begin
      sum[SUM_W-1:0]           = s1_px_r[SUM_W-1:0] + base[SUM_W-1:0];
      sum[2*SUM_W-1:SUM_W]     = s1_px_r[2*SUM_W-1:SUM_W] + base[2*SUM_W-1:SUM_W];
      sum[3*SUM_W-1:2*SUM_W]   = s1_px_r[3*SUM_W-1:2*SUM_W] + base[3*SUM_W-1:2*SUM_W];
      sum[4*SUM_W-1:3*SUM_W]   = s1_px_r[4*SUM_W-1:3*SUM_W] + base[4*SUM_W-1:3*SUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dc_r       <= dc;
      s1_first_r    <= first_in;
      s1_last_r     <= last_in;
      s1_px_r       <= {a_in, b_in, g_in, r_in};
      s1_fwd_r      <= s1_valid_r && (s1_dc_r == dc);
      s1_fwd_data_r <= sum;
    end
  end

  bfmd_pack #(
    .SUM_W (SUM_W)
  ) u_pack (
    .r_sum        (sum[SUM_W-1:0]),
    .g_sum        (sum[2*SUM_W-1:SUM_W]),
    .b_sum        (sum[3*SUM_W-1:2*SUM_W]),
    .a_sum        (sum[4*SUM_W-1:3*SUM_W]),
    .cfg          (cfg),
    .dst_pixel    (dst_pixel),
    .format_error (format_error)
  );

  assign out_load = s1_adv && s1_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dst_r <= dst_pixel;
      out_err_r <= format_error;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.dst_pixel    = out_dst_r;
  assign out_if.format_error = out_err_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < cfg.width)
    else $error("column position beyond effective image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= row_max)
    else $error("row position beyond block height");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item did not reach the accumulate stage");

  a_result_from_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result appeared without a block end item");

endmodule

FILE: tb/box_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average checker
// Watches the configuration, pixel and result channels of the downsampler,
// keeps its own copy of the per-column partial sums and position, predicts
// each block average when a block's last pixel is accepted, and compares
// every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module box_average_checker #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_LOG2_DIVIDER = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  bfmd_cfg_if         cfg_if,
  bfmd_in_if          in_if,
  bfmd_out_if         out_if,
  output int unsigned mismatch_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  typedef struct packed {
    logic [bfmd_pkg::PIXEL_W-1:0] pixel;
    logic                         error;
  } block_average_t;

  block_average_t               averages_due[$];
  int                           red_line[LINE_DEPTH];
  int                           green_line[LINE_DEPTH];
  int                           blue_line[LINE_DEPTH];
  int                           alpha_line[LINE_DEPTH];
  logic [bfmd_pkg::WIDTH_W-1:0] image_width;
  logic [bfmd_pkg::LOG2_W-1:0]  log2_divider;
  bfmd_pkg::fmt_t               pixel_format;
  logic [1:0]                   alpha_mode;
  int unsigned                  column_pos;
  int unsigned                  row_pos;
  int unsigned                  errors_seen;
  int unsigned                  results_seen;

  initial begin
    errors_seen  = 0;
    results_seen = 0;
  end

  task automatic add_pixel(input logic [bfmd_pkg::PIXEL_W-1:0] px);
    int unsigned    lg;
    int unsigned    span;
    int unsigned    row_len;
    int unsigned    col_idx;
    int unsigned    sh;
    int             r;
    int             g;
    int             b;
    int             a;
    logic [7:0]     aa;
    block_average_t avg;
    lg = log2_divider;
    if (lg < 1) lg = 1;
    if (lg > MAX_LOG2_DIVIDER) lg = MAX_LOG2_DIVIDER;
    span = 1 << lg;
    row_len = image_width;
    if (row_len > MAX_WIDTH) row_len = MAX_WIDTH;
    if (row_len < span) row_len = span;
    row_len = row_len & ~(span - 1);
    if (column_pos >= row_len) column_pos = 0;
    if (row_pos >= span) row_pos = 0;
    col_idx = (column_pos >> lg) % LINE_DEPTH;

    b = 0;
    a = 0;
    case (pixel_format)
      bfmd_pkg::FMT_RGBA8: begin
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        a = px[31:24];
      end
      bfmd_pkg::FMT_RG16U: begin
        r = px[15:0];
        g = px[31:16];
      end
      bfmd_pkg::FMT_RG16S: begin
        r = $signed(px[15:0]);
        g = $signed(px[31:16]);
      end
      default: begin
        r = $signed(px[7:0]);
        g = $signed(px[15:8]);
      end
    endcase

    if (!(row_pos == 0 && (column_pos & (span - 1)) == 0)) begin
      r += red_line[col_idx];
      g += green_line[col_idx];
      b += blue_line[col_idx];
      a += alpha_line[col_idx];
    end
    red_line[col_idx]   = r;
    green_line[col_idx] = g;
    blue_line[col_idx]  = b;
    alpha_line[col_idx] = a;

    if (row_pos == span - 1 && (column_pos & (span - 1)) == span - 1) begin
      avg.error = (pixel_format != bfmd_pkg::FMT_RGBA8) && (lg > 1);
      avg.pixel = '0;
      if (!avg.error) begin
        sh = 2 * lg;
        case (pixel_format)
          bfmd_pkg::FMT_RGBA8: begin
            aa = 8'(a >> sh);
            if (alpha_mode == bfmd_pkg::ALPHA_FORCE) begin
              aa = bfmd_pkg::ALPHA_OPAQUE;
            end else if (alpha_mode == bfmd_pkg::ALPHA_THRESH) begin
              aa = (aa >= bfmd_pkg::ALPHA_HALF) ? bfmd_pkg::ALPHA_OPAQUE : 8'h00;
            end
            avg.pixel = {aa, 8'(b >> sh), 8'(g >> sh), 8'(r >> sh)};
          end
          bfmd_pkg::FMT_RG16U: avg.pixel = {16'(g >> sh), 16'(r >> sh)};
          bfmd_pkg::FMT_RG16S: avg.pixel = {16'(g / (1 << sh)), 16'(r / (1 << sh))};
          default:   avg.pixel = {16'h0000, 8'(g / (1 << sh)), 8'(r / (1 << sh))};
        endcase
      end
      averages_due.push_back(avg);
    end

    column_pos++;
    if (column_pos >= row_len) begin
      column_pos = 0;
      row_pos++;
      if (row_pos >= span) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    block_average_t want;
    if (!rst_n) begin
      image_width  = bfmd_pkg::RST_IMAGE_WIDTH;
      log2_divider = bfmd_pkg::RST_LOG2_DIVIDER;
      pixel_format = bfmd_pkg::FMT_RGBA8;
      alpha_mode   = bfmd_pkg::ALPHA_PASS;
      column_pos   = 0;
      row_pos      = 0;
      averages_due.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          bfmd_pkg::REG_IMAGE_WIDTH:  image_width  = cfg_if.data[bfmd_pkg::WIDTH_W-1:0];
          bfmd_pkg::REG_LOG2_DIVIDER: log2_divider = cfg_if.data[bfmd_pkg::LOG2_W-1:0];
          bfmd_pkg::REG_PIXEL_FORMAT: pixel_format = bfmd_pkg::fmt_t'(cfg_if.data[1:0]);
          bfmd_pkg::REG_ALPHA_MODE:   alpha_mode   = cfg_if.data[1:0];
          default: ;
        endcase
        column_pos = 0;
        row_pos    = 0;
      end
      if (in_if.valid && in_if.ready) add_pixel(in_if.src_pixel);
      if (out_if.valid && out_if.ready) begin
        if (averages_due.size() == 0) begin
          $display("%0t: result item with none expected: dst_pixel %h format_error %b",
                   $time, out_if.dst_pixel, out_if.format_error);
          errors_seen++;
        end else begin
          want = averages_due.pop_front();
          if (out_if.dst_pixel !== want.pixel) begin
            $display("%0t: dst_pixel mismatch: expected %h, actual %h",
                     $time, want.pixel, out_if.dst_pixel);
            errors_seen++;
          end
          if (out_if.format_error !== want.error) begin
            $display("%0t: format_error mismatch: expected %b, actual %b",
                     $time, want.error, out_if.format_error);
            errors_seen++;
          end
          results_seen++;
        end
      end
    end
    mismatch_count <= errors_seen;
    pending_count  <= averages_due.size();
    checked_count  <= results_seen;
  end

endmodule

FILE: tb/tb_box_filter_mipmap_downsampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter mipmap downsampler testbench
// Writes a series of configurations, from directed corner cases to randomized
// widths, dividers, formats and alpha modes, and streams raster pixels with
// random gaps and result stalls. The checker predicts and compares every
// result item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_box_filter_mipmap_downsampler_unit;

  localparam int MAX_WIDTH        = 4096;
  localparam int MAX_LOG2_DIVIDER = 4;
  localparam int SETTLE_CYCLES    = 8;
  localparam int STALL_LIMIT      = 2000;
  localparam int TARGET_PIXELS    = 1650;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned pixels_sent = 0;
  int unsigned config_writes = 0;
  int unsigned phases_run = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  bfmd_cfg_if cfg_if ();
  bfmd_in_if  in_if ();
  bfmd_out_if out_if ();

  always #5 clk = ~clk;

  box_filter_mipmap_downsampler_unit #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_LOG2_DIVIDER (MAX_LOG2_DIVIDER)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  box_average_checker #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_LOG2_DIVIDER (MAX_LOG2_DIVIDER)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_if         (cfg_if),
    .in_if          (in_if),
    .out_if         (out_if),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  function automatic int unsigned random_gap();
    int unsigned pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [bfmd_pkg::PIXEL_W-1:0] pick_pixel(input bit extreme);
    if (!extreme) return $urandom;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8080_8080;
      3: return 32'h7F7F_7F7F;
      4: return 32'h8000_8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [bfmd_pkg::WIDTH_W-1:0] width,
                              input logic [bfmd_pkg::LOG2_W-1:0] lg,
                              input bfmd_pkg::fmt_t fmt, input logic [1:0] alpha);
    logic [bfmd_pkg::CFG_IDX_W-1:0]  order[4];
    logic [bfmd_pkg::CFG_DATA_W-1:0] values[4];
    order  = '{bfmd_pkg::REG_IMAGE_WIDTH, bfmd_pkg::REG_LOG2_DIVIDER,
               bfmd_pkg::REG_PIXEL_FORMAT, bfmd_pkg::REG_ALPHA_MODE};
    values = '{width, {10'($urandom), lg}, {11'($urandom), fmt}, {11'($urandom), alpha}};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[i];
      cfg_if.data  <= values[i];
      do @(posedge clk); while (!cfg_if.ready);
      config_writes++;
    end
    cfg_if.valid <= 1'b0;
    phases_run++;
  endtask

  task automatic stream_pixels(input logic [bfmd_pkg::PIXEL_W-1:0] pix[$]);
    int unsigned gap;
    foreach (pix[i]) begin
      gap = random_gap();
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid     <= 1'b1;
      in_if.src_pixel <= pix[i];
      do @(posedge clk); while (!in_if.ready);
      pixels_sent++;
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (random_gap() != 0) begin
        out_if.ready <= 1'b0;
        repeat (random_gap() + 1) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_box_filter_mipmap_downsampler_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [bfmd_pkg::PIXEL_W-1:0] burst[$];
    int unsigned                  random_pixels;
    int unsigned                  lg;
    int unsigned                  span;
    int unsigned                  row_len;
    int unsigned                  block_row;
    int unsigned                  count;
    int unsigned                  pick;
    logic [bfmd_pkg::WIDTH_W-1:0] width;
    logic [bfmd_pkg::LOG2_W-1:0]  lg_code;
    bit                           extreme;

    rst_n            = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = bfmd_pkg::REG_IMAGE_WIDTH;
    cfg_if.data      = '0;
    in_if.valid      = 1'b0;
    in_if.src_pixel  = '0;
    random_pixels    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    settle();
    write_config(13'd2, 3'd1, bfmd_pkg::FMT_RGBA8, bfmd_pkg::ALPHA_FORCE);
    burst = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
    stream_pixels(burst);

    settle();
    write_config(13'd2, 3'd1, bfmd_pkg::FMT_RGBA8, bfmd_pkg::ALPHA_THRESH);
    burst = {32'h8000_0000, 32'h8000_0000, 32'h7F00_0000, 32'h8100_0000,
             32'h7F00_0000, 32'h7F00_0000, 32'h8000_0000, 32'h7F00_0000};
    stream_pixels(burst);

    // A divider code of zero behaves as the smallest block.
    settle();
    write_config(13'd2, 3'd0, bfmd_pkg::FMT_RG16U, bfmd_pkg::ALPHA_PASS);
    burst = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    stream_pixels(burst);

    // An odd width is rounded down to a whole number of blocks.
    settle();
    write_config(13'd3, 3'd1, bfmd_pkg::FMT_RG16S, bfmd_pkg::ALPHA_PASS);
    burst = {32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h7FFF_7FFF};
    stream_pixels(burst);

    // Negative sums must round toward zero; the unused alpha code is written too, though this format carries no alpha.
    settle();
    write_config(13'd2, 3'd1, bfmd_pkg::FMT_RG8S, 2'd3);
    burst = {32'hFFFF_FF81, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    stream_pixels(burst);

    while (random_pixels < TARGET_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) lg_code = 3'd1;
      else if (pick < 6) lg_code = 3'd2;
      else if (pick < 7) lg_code = 3'd3;
      else if (pick < 8) lg_code = 3'd4;
      else lg_code = 3'($urandom_range(0, 7));
      lg = lg_code;
      if (lg < 1) lg = 1;
      if (lg > MAX_LOG2_DIVIDER) lg = MAX_LOG2_DIVIDER;
      span = 1 << lg;
      if ($urandom_range(0, 4) == 0) width = 13'($urandom_range(0, 4 * span));
      else width = 13'(span * $urandom_range(1, (lg <= 2) ? 8 : (lg == 3) ? 4 : 2));
      row_len = width;
      if (row_len > MAX_WIDTH) row_len = MAX_WIDTH;
      if (row_len < span) row_len = span;
      row_len = row_len & ~(span - 1);
      block_row = row_len * span;
      count = block_row * $urandom_range(1, (block_row >= 256) ? 1 : 256 / block_row);
      if ($urandom_range(0, 4) == 0) count += $urandom_range(1, block_row - 1);
      extreme = ($urandom_range(0, 3) == 0);
      burst.delete();
      repeat (count) burst.push_back(pick_pixel(extreme));

      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      write_config(width, lg_code, bfmd_pkg::fmt_t'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)));
      stream_pixels(burst);
      random_pixels += count;
    end

    settle();
    $display("Run covered %0d pixel items and %0d checked block results over %0d configurations.",
             pixels_sent, checked_count, phases_run);
    $display("It made %0d register writes across all formats, dividers, alpha modes and widths.",
             config_writes);
    if (mismatch_count == 0) begin
      $display("tb_box_filter_mipmap_downsampler_unit: PASS");
    end else begin
      $display("tb_box_filter_mipmap_downsampler_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: box_filter_mipmap_downsampler_unit.f
rtl/bfmd_pkg.sv
rtl/bfmd_if.sv
rtl/bfmd_cfg_regs.sv
rtl/bfmd_line_mem.sv
rtl/bfmd_pack.sv
rtl/box_filter_mipmap_downsampler_unit.sv
tb/box_average_checker.sv
tb/tb_box_filter_mipmap_downsampler_unit.sv
